@@ rtl/source_text_tokenizer_defines.svh @@
// Assertion macros for the tokenizer checker.
// Clock and reset are taken from the scope as clk and rst.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication.
`define STT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication.
`define STT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

@@ rtl/stt_pkg.sv @@
// Shared types and constants for the source text tokenizer.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int LINE_WIDTH_DEF   = 16;
  localparam int COLUMN_WIDTH_DEF = 16;
  localparam int OUT_DEPTH        = 4;

  localparam int KIND_W = 5;
  localparam int POS_W  = 16;
  localparam int ERR_W  = 2;
  localparam int TDATA_W = 56;

  // token kinds
  localparam logic [KIND_W-1:0] K_NUMBER = 5'd0;
  localparam logic [KIND_W-1:0] K_IDENT  = 5'd1;
  localparam logic [KIND_W-1:0] K_IF     = 5'd2;
  localparam logic [KIND_W-1:0] K_ELSE   = 5'd3;
  localparam logic [KIND_W-1:0] K_END    = 5'd4;
  localparam logic [KIND_W-1:0] K_STRING = 5'd5;
  localparam logic [KIND_W-1:0] K_PLUS   = 5'd6;
  localparam logic [KIND_W-1:0] K_MINUS  = 5'd7;
  localparam logic [KIND_W-1:0] K_STAR   = 5'd8;
  localparam logic [KIND_W-1:0] K_SLASH  = 5'd9;
  localparam logic [KIND_W-1:0] K_LPAREN = 5'd10;
  localparam logic [KIND_W-1:0] K_RPAREN = 5'd11;
  localparam logic [KIND_W-1:0] K_COMMA  = 5'd12;
  localparam logic [KIND_W-1:0] K_DOT    = 5'd13;
  localparam logic [KIND_W-1:0] K_EQ     = 5'd14;
  localparam logic [KIND_W-1:0] K_EQEQ   = 5'd15;
  localparam logic [KIND_W-1:0] K_GT     = 5'd16;
  localparam logic [KIND_W-1:0] K_GE     = 5'd17;
  localparam logic [KIND_W-1:0] K_LT     = 5'd18;
  localparam logic [KIND_W-1:0] K_LE     = 5'd19;
  localparam logic [KIND_W-1:0] K_NE     = 5'd20;
  localparam logic [KIND_W-1:0] K_EOF    = 5'd21;
  localparam logic [KIND_W-1:0] K_ERROR  = 5'd22;

  // error codes
  localparam logic [ERR_W-1:0] E_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] E_STRING = 2'd1;
  localparam logic [ERR_W-1:0] E_BANG   = 2'd2;
  localparam logic [ERR_W-1:0] E_CHAR   = 2'd3;

  // pending operator codes
  localparam logic [1:0] P_EQ   = 2'd0;
  localparam logic [1:0] P_GT   = 2'd1;
  localparam logic [1:0] P_LT   = 2'd2;
  localparam logic [1:0] P_BANG = 2'd3;

  // input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;

  // keyword prefixes, characters packed first-in-highest
  localparam logic [31:0] KW_IF   = 32'h0000_6966;
  localparam logic [31:0] KW_ELSE = 32'h656C_7365;
  localparam logic [31:0] KW_END  = 32'h0065_6E64;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  line;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  len;
    logic [ERR_W-1:0]  err;
    logic              last;
  } result_t;

endpackage

@@ rtl/source_text_tokenizer.sv @@
// Source text tokenizer: one byte per beat in, one token per beat out.
// A token is written into the result queue with the beat that ends it and presented from the queue head.
// Throughput: one input beat per cycle while ready; a beat that closes one token and opens another
// yields two tokens, drained one per cycle while the sink is ready, through a 4-entry result queue.
// Input is stalled only while the queue lacks room for two tokens.
// Reset (rst, synchronous): scanner idle, line and column at 1, queue empty.
`timescale 1ns / 1ps

module source_text_tokenizer
  import stt_pkg::*;
#(
  parameter int LINE_WIDTH   = LINE_WIDTH_DEF,
  parameter int COLUMN_WIDTH = COLUMN_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] text_byte
  input  logic               s_axis_tuser,   // [0] opcode
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [15:0] tok_line, [31:16] start_column, [47:32] text_length,
  // [49:48] error_code, [55:50] zero
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [KIND_W-1:0]  m_axis_tuser,   // [4:0] token_kind
  output logic               m_axis_tlast    // last_of_run
);

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_NUMBER  = 7'b0000010,
    M_IDENT   = 7'b0000100,
    M_STRING  = 7'b0001000,
    M_COMMENT = 7'b0010000,
    M_PENDING = 7'b0100000,
    M_ERROR   = 7'b1000000
  } mode_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == 8'h5F);
  endfunction

  function automatic result_t mk_res(input logic [KIND_W-1:0] kind,
                                     input logic [POS_W-1:0] line,
                                     input logic [POS_W-1:0] col,
                                     input logic [POS_W-1:0] len,
                                     input logic [ERR_W-1:0] err);
    result_t r;
    r.kind = kind;
    r.line = line;
    r.col  = col;
    r.len  = len;
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

  // scanner state
  mode_t                   mode, mode_next;
  logic [LINE_WIDTH-1:0]   line_cnt, line_cnt_next;
  logic [COLUMN_WIDTH-1:0] col_cnt, col_cnt_next;
  logic [COLUMN_WIDTH-1:0] tok_col, tok_col_next;
  logic [POS_W-1:0]        tok_len, tok_len_next;
  logic                    dot_seen, dot_seen_next;
  logic [31:0]             kw_prefix, kw_prefix_next;
  logic [1:0]              pend_op, pend_op_next;

  // result queue
  result_t                 q_mem [OUT_DEPTH];
  logic [PTR_W-1:0]        wr_ptr, rd_ptr;
  logic [CNT_W-1:0]        q_cnt;

  logic             in_fire, out_fire;
  logic [7:0]       c;
  logic             is_eos;
  logic             do_dispatch;
  logic             close_vld, disp_vld;
  result_t          close_res, disp_res;
  result_t          first_res, second_res;
  logic [POS_W-1:0] line16, col16, tok_col16;
  logic [KIND_W-1:0] word_kind, pend_single_kind, pend_double_kind;
  logic [POS_W-1:0] len_grow;

  assign c       = s_axis_tdata;
  assign is_eos  = (s_axis_tuser == OP_EOS);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign line16    = POS_W'(line_cnt);
  assign col16     = POS_W'(col_cnt);
  assign tok_col16 = POS_W'(tok_col);
  assign len_grow  = (tok_len == '1) ? tok_len : tok_len + POS_W'(1);

  always_comb begin
    word_kind = K_IDENT;
    if (tok_len == POS_W'(2) && kw_prefix == KW_IF) word_kind = K_IF;
    else if (tok_len == POS_W'(4) && kw_prefix == KW_ELSE) word_kind = K_ELSE;
    else if (tok_len == POS_W'(3) && kw_prefix == KW_END) word_kind = K_END;
  end

  assign pend_single_kind = K_EQ + {2'b00, pend_op, 1'b0};
  assign pend_double_kind = (pend_op == P_BANG) ? K_NE : pend_single_kind + KIND_W'(1);

  // next-state and token generation for one beat
  always_comb begin
    mode_next      = mode;
    line_cnt_next  = line_cnt;
    col_cnt_next   = col_cnt;
    tok_col_next   = tok_col;
    tok_len_next   = tok_len;
    dot_seen_next  = dot_seen;
    kw_prefix_next = kw_prefix;
    pend_op_next   = pend_op;
    do_dispatch    = 1'b0;
    close_vld      = 1'b0;
    disp_vld       = 1'b0;
    close_res      = mk_res(K_NUMBER, line16, tok_col16, tok_len, E_NONE);
    disp_res       = mk_res(K_EOF, line16, col16, '0, E_NONE);

    if (is_eos) begin
      disp_vld = 1'b1;
      unique case (mode)
        M_NUMBER: begin
          close_vld = 1'b1;
        end
        M_IDENT: begin
          close_vld = 1'b1;
          close_res = mk_res(word_kind, line16, tok_col16, tok_len, E_NONE);
        end
        M_STRING: begin
          close_vld = 1'b1;
          close_res = mk_res(K_ERROR, line16, tok_col16, '0, E_STRING);
          disp_vld  = 1'b0;
        end
        M_PENDING: begin
          close_vld = 1'b1;
          if (pend_op == P_BANG) begin
            close_res = mk_res(K_ERROR, line16, tok_col16, '0, E_BANG);
            disp_vld  = 1'b0;
          end else begin
            close_res = mk_res(pend_single_kind, line16, tok_col16, POS_W'(1), E_NONE);
          end
        end
        M_ERROR: begin
          disp_vld = 1'b0;
        end
        default: begin
        end
      endcase
      // back to reset values for the next source
      mode_next      = M_IDLE;
      line_cnt_next  = LINE_WIDTH'(1);
      col_cnt_next   = COLUMN_WIDTH'(1);
      tok_col_next   = '0;
      tok_len_next   = '0;
      dot_seen_next  = 1'b0;
      kw_prefix_next = '0;
      pend_op_next   = P_EQ;
    end else begin
      unique case (mode)
        M_NUMBER: begin
          if (is_digit(c)) begin
            tok_len_next = len_grow;
          end else if (c == CH_DOT && !dot_seen) begin
            dot_seen_next = 1'b1;
            tok_len_next  = len_grow;
          end else begin
            close_vld   = 1'b1;
            do_dispatch = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (tok_len < POS_W'(4)) kw_prefix_next = {kw_prefix[23:0], c};
            tok_len_next = len_grow;
          end else begin
            close_vld   = 1'b1;
            close_res   = mk_res(word_kind, line16, tok_col16, tok_len, E_NONE);
            do_dispatch = 1'b1;
          end
        end
        M_STRING: begin
          if (c == CH_QUOTE) begin
            close_vld = 1'b1;
            close_res = mk_res(K_STRING, line16, tok_col16, tok_len, E_NONE);
            mode_next = M_IDLE;
          end else if (c == CH_NL) begin
            close_vld = 1'b1;
            close_res = mk_res(K_ERROR, line16, tok_col16, '0, E_STRING);
            mode_next = M_ERROR;
          end else begin
            tok_len_next = len_grow;
          end
        end
        M_COMMENT: begin
          if (c == CH_NL) mode_next = M_IDLE;
        end
        M_PENDING: begin
          close_vld = 1'b1;
          if (c == CH_EQ) begin
            close_res = mk_res(pend_double_kind, line16, tok_col16, POS_W'(2), E_NONE);
            mode_next = M_IDLE;
          end else if (pend_op == P_BANG) begin
            // lone bang swallows the byte after it
            close_res = mk_res(K_ERROR, line16, tok_col16, '0, E_BANG);
            mode_next = M_ERROR;
          end else begin
            close_res   = mk_res(pend_single_kind, line16, tok_col16, POS_W'(1), E_NONE);
            do_dispatch = 1'b1;
          end
        end
        M_ERROR: begin
        end
        default: begin
          do_dispatch = 1'b1;
        end
      endcase

      // start of a new token
      if (do_dispatch) begin
        mode_next    = M_IDLE;
        tok_col_next = col_cnt;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL) begin
          mode_next = M_IDLE;
        end else if (c == CH_HASH) begin
          mode_next = M_COMMENT;
        end else if (is_digit(c)) begin
          mode_next     = M_NUMBER;
          tok_len_next  = POS_W'(1);
          dot_seen_next = 1'b0;
        end else if (is_alpha(c)) begin
          mode_next      = M_IDENT;
          tok_len_next   = POS_W'(1);
          kw_prefix_next = {24'h0, c};
        end else if (c == CH_QUOTE) begin
          mode_next    = M_STRING;
          tok_len_next = '0;
        end else begin
          disp_vld = 1'b1;
          disp_res = mk_res(K_ERROR, line16, col16, '0, E_CHAR);
          case (c)
            CH_PLUS:   disp_res.kind = K_PLUS;
            CH_MINUS:  disp_res.kind = K_MINUS;
            CH_STAR:   disp_res.kind = K_STAR;
            CH_SLASH:  disp_res.kind = K_SLASH;
            CH_LPAREN: disp_res.kind = K_LPAREN;
            CH_RPAREN: disp_res.kind = K_RPAREN;
            CH_COMMA:  disp_res.kind = K_COMMA;
            CH_DOT:    disp_res.kind = K_DOT;
            CH_EQ, CH_GT, CH_LT, CH_BANG: begin
              disp_vld  = 1'b0;
              mode_next = M_PENDING;
              case (c)
                CH_EQ:   pend_op_next = P_EQ;
                CH_GT:   pend_op_next = P_GT;
                CH_LT:   pend_op_next = P_LT;
                default: pend_op_next = P_BANG;
              endcase
            end
            default:   mode_next = M_ERROR;
          endcase
          if (disp_vld && disp_res.kind != K_ERROR) begin
            disp_res.len = POS_W'(1);
            disp_res.err = E_NONE;
          end
        end
      end

      // position counters, saturating
      if (c == CH_NL) begin
        line_cnt_next = (line_cnt == '1) ? line_cnt : line_cnt + LINE_WIDTH'(1);
        col_cnt_next  = COLUMN_WIDTH'(1);
      end else begin
        col_cnt_next = (col_cnt == '1) ? col_cnt : col_cnt + COLUMN_WIDTH'(1);
      end
    end
  end

  // order the beat's tokens and mark the last one
  always_comb begin
    first_res  = close_vld ? close_res : disp_res;
    second_res = disp_res;
    first_res.last  = !(close_vld && disp_vld);
    second_res.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      line_cnt  <= LINE_WIDTH'(1);
      col_cnt   <= COLUMN_WIDTH'(1);
      tok_col   <= '0;
      tok_len   <= '0;
      dot_seen  <= 1'b0;
      kw_prefix <= '0;
      pend_op   <= P_EQ;
    end else if (in_fire) begin
      mode      <= mode_next;
      line_cnt  <= line_cnt_next;
      col_cnt   <= col_cnt_next;
      tok_col   <= tok_col_next;
      tok_len   <= tok_len_next;
      dot_seen  <= dot_seen_next;
      kw_prefix <= kw_prefix_next;
      pend_op   <= pend_op_next;
    end
  end

  // result queue: up to two writes, one read per cycle
  logic [1:0] push_n;

  always_comb begin
    push_n = 2'd0;
    if (in_fire) push_n = {1'b0, close_vld} + {1'b0, disp_vld};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (out_fire) rd_ptr <= rd_ptr + PTR_W'(1);
      q_cnt <= q_cnt + CNT_W'(push_n) - CNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_mem[wr_ptr] <= first_res;
    if (push_n == 2'd2) q_mem[wr_ptr + PTR_W'(1)] <= second_res;
  end

  assign s_axis_tready = (q_cnt <= CNT_W'(OUT_DEPTH - 2));
  assign m_axis_tvalid = (q_cnt != '0);
  assign m_axis_tuser  = q_mem[rd_ptr].kind;
  assign m_axis_tlast  = q_mem[rd_ptr].last;
  assign m_axis_tdata  = {6'b0, q_mem[rd_ptr].err, q_mem[rd_ptr].len,
                          q_mem[rd_ptr].col, q_mem[rd_ptr].line};

endmodule

@@ rtl/stt_checker.sv @@
// Port-level checks for the source text tokenizer, bound to the top level.
// Depends on stt_pkg and source_text_tokenizer_defines.svh.
`timescale 1ns / 1ps
`include "source_text_tokenizer_defines.svh"

module stt_checker
  import stt_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [KIND_W-1:0]  m_axis_tuser,
  input logic               m_axis_tlast
);

  logic              out_wait;
  logic [POS_W-1:0]  out_len;
  logic [ERR_W-1:0]  out_err;
  logic              is_op2;

  assign out_wait = m_axis_tvalid && !m_axis_tready;
  assign out_len  = m_axis_tdata[47:32];
  assign out_err  = m_axis_tdata[49:48];
  assign is_op2   = (m_axis_tuser == K_EQEQ) || (m_axis_tuser == K_GE) ||
                    (m_axis_tuser == K_LE) || (m_axis_tuser == K_NE);

  // a stalled beat holds
  `STT_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid && $stable(m_axis_tdata))

  // end of file closes its run and carries no text
  `STT_ASSERT_NOW(a_eof_last, m_axis_tvalid && m_axis_tuser == K_EOF, m_axis_tlast && out_len == '0)

  // error code is set exactly on error tokens
  `STT_ASSERT_NOW(a_err_code, m_axis_tvalid, (m_axis_tuser == K_ERROR) == (out_err != E_NONE))

  // two-character operators are two long
  `STT_ASSERT_NOW(a_op2_len, m_axis_tvalid && is_op2, out_len == POS_W'(2))

  // an empty queue always takes input
  `STT_ASSERT_NOW(a_empty_ready, !m_axis_tvalid, s_axis_tready)

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking bench for source_text_tokenizer: byte/end-of-source beats in, token beats out.
// Holds a token scoreboard class with its own scanner model; depends only on stt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import stt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 400;
  localparam int LIVE_TARGET    = 760;

  class token_scoreboard;
    typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_NUMBER, SCAN_WORD, SCAN_STRING, SCAN_COMMENT, SCAN_OPERATOR, SCAN_DISCARD
    } scan_t;

    scan_t                     mode;
    logic [LINE_WIDTH_DEF-1:0]   line_no;
    logic [COLUMN_WIDTH_DEF-1:0] col_no;
    logic [COLUMN_WIDTH_DEF-1:0] tok_col;
    logic [15:0]               tok_len;
    logic                      dot;
    logic [31:0]               prefix;
    logic [1:0]                pend_op;
    result_t                   tokens_due[$];
    result_t                   beat_tokens[$];
    int                        errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode    = SCAN_IDLE;
      line_no = 1;
      col_no  = 1;
      tok_col = 0;
      tok_len = 0;
      dot     = 1'b0;
      prefix  = 0;
      pend_op = P_EQ;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function void emit(logic [KIND_W-1:0] kind, logic [COLUMN_WIDTH_DEF-1:0] col,
                       logic [15:0] len, logic [ERR_W-1:0] err);
      result_t r;
      r.kind = kind;
      r.line = POS_W'(line_no);
      r.col  = POS_W'(col);
      r.len  = len;
      r.err  = err;
      r.last = 1'b0;
      beat_tokens = {beat_tokens, r};
    endfunction

    function void grow();
      if (tok_len != 16'hFFFF) tok_len++;
    endfunction

    function void emit_word();
      logic [KIND_W-1:0] kind;
      kind = K_IDENT;
      if (tok_len == 2 && prefix == KW_IF) kind = K_IF;
      else if (tok_len == 4 && prefix == KW_ELSE) kind = K_ELSE;
      else if (tok_len == 3 && prefix == KW_END) kind = K_END;
      emit(kind, tok_col, tok_len, E_NONE);
    endfunction

    // single-char form of the held operator (never the bang)
    function void emit_pending_single();
      case (pend_op)
        P_GT:    emit(K_GT, tok_col, 1, E_NONE);
        P_LT:    emit(K_LT, tok_col, 1, E_NONE);
        default: emit(K_EQ, tok_col, 1, E_NONE);
      endcase
    endfunction

    function void start_token(logic [7:0] c);
      mode    = SCAN_IDLE;
      tok_col = col_no;
      case (c)
        CH_SPACE, CH_TAB, CH_CR, CH_NL: ;
        CH_HASH:   mode = SCAN_COMMENT;
        CH_QUOTE: begin
          mode    = SCAN_STRING;
          tok_len = 0;
        end
        CH_PLUS:   emit(K_PLUS, col_no, 1, E_NONE);
        CH_MINUS:  emit(K_MINUS, col_no, 1, E_NONE);
        CH_STAR:   emit(K_STAR, col_no, 1, E_NONE);
        CH_SLASH:  emit(K_SLASH, col_no, 1, E_NONE);
        CH_LPAREN: emit(K_LPAREN, col_no, 1, E_NONE);
        CH_RPAREN: emit(K_RPAREN, col_no, 1, E_NONE);
        CH_COMMA:  emit(K_COMMA, col_no, 1, E_NONE);
        CH_DOT:    emit(K_DOT, col_no, 1, E_NONE);
        CH_EQ: begin
          mode    = SCAN_OPERATOR;
          pend_op = P_EQ;
        end
        CH_GT: begin
          mode    = SCAN_OPERATOR;
          pend_op = P_GT;
        end
        CH_LT: begin
          mode    = SCAN_OPERATOR;
          pend_op = P_LT;
        end
        CH_BANG: begin
          mode    = SCAN_OPERATOR;
          pend_op = P_BANG;
        end
        default: begin
          if (is_digit(c)) begin
            mode    = SCAN_NUMBER;
            tok_len = 1;
            dot     = 1'b0;
          end else if (is_alpha(c)) begin
            mode    = SCAN_WORD;
            tok_len = 1;
            prefix  = {24'h0, c};
          end else begin
            mode = SCAN_DISCARD;
            emit(K_ERROR, col_no, 0, E_CHAR);
          end
        end
      endcase
    endfunction

    function bit in_discard();
      return mode == SCAN_DISCARD;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    // accepted input beat: work out the tokens it causes
    function void note_input(logic op, logic [7:0] c);
      bit with_eof;
      beat_tokens.delete();
      if (op == OP_EOS) begin
        with_eof = 1'b1;
        case (mode)
          SCAN_NUMBER: emit(K_NUMBER, tok_col, tok_len, E_NONE);
          SCAN_WORD:   emit_word();
          SCAN_STRING: begin
            emit(K_ERROR, tok_col, 0, E_STRING);
            with_eof = 1'b0;
          end
          SCAN_OPERATOR: begin
            if (pend_op == P_BANG) begin
              emit(K_ERROR, tok_col, 0, E_BANG);
              with_eof = 1'b0;
            end else begin
              emit_pending_single();
            end
          end
          SCAN_DISCARD: with_eof = 1'b0;
          default: ;
        endcase
        if (with_eof) emit(K_EOF, col_no, 0, E_NONE);
        clear_state();
      end else begin
        case (mode)
          SCAN_NUMBER: begin
            if (is_digit(c)) begin
              grow();
            end else if (c == CH_DOT && !dot) begin
              dot = 1'b1;
              grow();
            end else begin
              emit(K_NUMBER, tok_col, tok_len, E_NONE);
              start_token(c);
            end
          end
          SCAN_WORD: begin
            if (is_alpha(c) || is_digit(c)) begin
              if (tok_len < 4) prefix = {prefix[23:0], c};
              grow();
            end else begin
              emit_word();
              start_token(c);
            end
          end
          SCAN_STRING: begin
            if (c == CH_QUOTE) begin
              emit(K_STRING, tok_col, tok_len, E_NONE);
              mode = SCAN_IDLE;
            end else if (c == CH_NL) begin
              emit(K_ERROR, tok_col, 0, E_STRING);
              mode = SCAN_DISCARD;
            end else begin
              grow();
            end
          end
          SCAN_COMMENT: if (c == CH_NL) mode = SCAN_IDLE;
          SCAN_OPERATOR: begin
            if (c == CH_EQ) begin
              case (pend_op)
                P_GT:    emit(K_GE, tok_col, 2, E_NONE);
                P_LT:    emit(K_LE, tok_col, 2, E_NONE);
                P_BANG:  emit(K_NE, tok_col, 2, E_NONE);
                default: emit(K_EQEQ, tok_col, 2, E_NONE);
              endcase
              mode = SCAN_IDLE;
            end else if (pend_op == P_BANG) begin
              emit(K_ERROR, tok_col, 0, E_BANG);
              mode = SCAN_DISCARD;
            end else begin
              emit_pending_single();
              start_token(c);
            end
          end
          SCAN_DISCARD: ;
          default: start_token(c);
        endcase
        if (c == CH_NL) begin
          if (line_no != '1) line_no++;
          col_no = 1;
        end else if (col_no != '1) begin
          col_no++;
        end
      end
      if (beat_tokens.size() > 0) beat_tokens[$].last = 1'b1;
      foreach (beat_tokens[i]) tokens_due = {tokens_due, beat_tokens[i]};
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got, logic [5:0] pad);
      result_t want;
      if (tokens_due.size() == 0) begin
        $error("unexpected token beat: kind %0d line %0d col %0d", got.kind, got.line, got.col);
        errors++;
        return;
      end
      want = tokens_due.pop_front();
      check_field("token_kind", 16'(want.kind), 16'(got.kind));
      check_field("tok_line", want.line, got.line);
      check_field("start_column", want.col, got.col);
      check_field("text_length", want.len, got.len);
      check_field("error_code", 16'(want.err), 16'(got.err));
      check_field("last_of_run", 16'(want.last), 16'(got.last));
      check_field("tdata_padding", 16'h0, 16'(pad));
    endfunction
  endclass

  logic               clk;
  logic               rst           = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = 8'h00;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]  m_axis_tuser;
  logic               m_axis_tlast;

  token_scoreboard sb = new();
  bit              steady     = 1'b0;  // no idle cycles on either side
  bit              hold_done  = 1'b0;
  int unsigned     live_items = 0;     // beats not swallowed after an error

  source_text_tokenizer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // valid stays high across back-to-back beats; only lowered for a gap
  task automatic send_item(input logic op, input logic [7:0] b);
    bit was_live;
    if (!steady) begin
      while ($urandom_range(0, 99) < 16) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    was_live = !sb.in_discard();
    sb.note_input(op, b);
    if (was_live) live_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
  endtask

  // sink side: random stalls, one long hold-off to back up the result queue
  initial begin
    forever begin
      @(posedge clk);
      if (!hold_done && live_items >= 300) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result({m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                       m_axis_tdata[47:32], m_axis_tdata[49:48], m_axis_tlast},
                      m_axis_tdata[55:50]);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    string       alnum;
    string       digits;
    string       ops;
    string       gaps;
    string       words[6];
    int unsigned pick;
    int unsigned len;
    int unsigned dot_at;
    logic [7:0]  ch;

    alnum    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    digits   = "0123456789";
    ops      = "+-*/(),.=<>!";
    gaps     = " \t\r\n";
    words[0] = "if";
    words[1] = "else";
    words[2] = "end";
    words[3] = "elsewhere";
    words[4] = "en";
    words[5] = "iff";

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // keyword ended by an operator (two tokens on one beat), dotted number, '==',
    // then a lone bang; the trailing byte and end of source are swallowed
    send_text("if+1.5==!a");
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_EOS, 8'h00);
    // string broken by a newline
    send_text("\"s\n");
    send_item(OP_EOS, 8'hFF);
    // stray character
    send_text("@");
    send_item(OP_EOS, 8'h5A);
    // comment, keywords, pending '<' flushed by a letter, word flushed at end of source
    send_text("#c\nelse<end");
    send_item(OP_EOS, 8'hA5);

    while (live_items < LIVE_TARGET) begin
      steady = (live_items >= 500 && live_items < 650);
      pick   = $urandom_range(0, 99);
      if (sb.in_discard()) begin
        repeat ($urandom_range(0, 2)) send_item(OP_BYTE, 8'($urandom));
        send_item(OP_EOS, 8'($urandom));
      end else if (pick < 18) begin
        if ($urandom_range(0, 3) == 0) begin
          send_text(words[$urandom_range(0, 5)]);
        end else begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++)
            send_item(OP_BYTE, alnum[$urandom_range(0, (i == 0) ? 52 : 62)]);
        end
      end else if (pick < 32) begin
        len    = $urandom_range(1, 5);
        dot_at = $urandom_range(0, len + 1);
        for (int i = 0; i < len; i++) begin
          send_item(OP_BYTE, digits[$urandom_range(0, 9)]);
          if (i == dot_at) send_item(OP_BYTE, CH_DOT);
        end
        if ($urandom_range(0, 5) == 0) begin
          send_item(OP_BYTE, CH_DOT);
          send_item(OP_BYTE, digits[$urandom_range(0, 9)]);
        end
      end else if (pick < 42) begin
        send_item(OP_BYTE, CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 9) == 0) ch = 8'($urandom_range(128, 255));
          else ch = 8'($urandom_range(32, 126));
          if (ch == CH_QUOTE) ch = "x";
          send_item(OP_BYTE, ch);
        end
        pick = $urandom_range(0, 19);
        if (pick < 2) send_item(OP_BYTE, CH_NL);
        else if (pick == 2) send_item(OP_EOS, 8'($urandom));
        else send_item(OP_BYTE, CH_QUOTE);
      end else if (pick < 62) begin
        ch = ops[$urandom_range(0, ops.len() - 1)];
        send_item(OP_BYTE, ch);
        if (ch == CH_BANG) begin
          if ($urandom_range(0, 7) != 0) send_item(OP_BYTE, CH_EQ);
        end else if ((ch == CH_EQ || ch == CH_LT || ch == CH_GT) && $urandom_range(0, 1)) begin
          send_item(OP_BYTE, CH_EQ);
        end
      end else if (pick < 82) begin
        send_item(OP_BYTE, gaps[$urandom_range(0, 3)]);
      end else if (pick < 88) begin
        send_item(OP_BYTE, CH_HASH);
        repeat ($urandom_range(0, 5)) begin
          ch = 8'($urandom);
          if (ch == CH_NL) ch = CH_HASH;
          send_item(OP_BYTE, ch);
        end
        send_item(OP_BYTE, CH_NL);
      end else if (pick < 96) begin
        send_item(OP_BYTE, 8'($urandom));
      end else begin
        send_item(OP_EOS, 8'($urandom));
      end
    end
    steady = 1'b0;
    send_item(OP_EOS, 8'h00);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
